// ===== design/trapint4d_pkg.sv =====
// Shared types, constants and helpers for the 4-D trapezoid integrator.
// No dependencies; every other file of the block imports this package.
package trapint4d_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned NumDims   = 4;
  localparam int unsigned SizeW     = 7;
  localparam int unsigned PosW      = $clog2(MaxPoints);
  localparam int unsigned SampleW   = 32;
  localparam int unsigned StepW     = 32;
  localparam int unsigned SumW      = 60;
  localparam int unsigned ResW      = 64;
  localparam int unsigned LimbW     = 32;
  localparam int unsigned ProdW     = 2 * LimbW;
  localparam int unsigned AccW      = 192;
  localparam int unsigned FracCut   = 100;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [SizeW-1:0] SizeMin   = SizeW'(2);
  localparam logic [SizeW-1:0] SizeMax   = SizeW'(MaxPoints);
  localparam logic [SizeW-1:0] SizeReset = SizeW'(2);
  localparam logic [StepW-1:0] StepReset = StepW'(32'h0100_0000);

  localparam logic [ResW-1:0] ResPosMax = {1'b0, {(ResW-1){1'b1}}};
  localparam logic [ResW-1:0] ResNegMax = {1'b1, {(ResW-1){1'b0}}};

  typedef enum logic [RegIdxW-1:0] {
    REG_SIZE_DIM0 = 3'd0,
    REG_SIZE_DIM1 = 3'd1,
    REG_SIZE_DIM2 = 3'd2,
    REG_SIZE_DIM3 = 3'd3,
    REG_GRID_STEP = 3'd4
  } reg_idx_t;

  typedef logic [NumDims-1:0][SizeW-1:0] sizes_t;

  // One finished grid: raw weighted sum (Q40.20) and the spacing to scale by.
  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [StepW-1:0] step;
  } job_t;

  // Last index of a dimension, with the size clamped to [2, MaxPoints].
  function automatic logic [PosW-1:0] last_idx(input logic [SizeW-1:0] s);
    logic [SizeW-1:0] e;
    e = s;
    if (s < SizeMin) e = SizeMin;
    else if (s > SizeMax) e = SizeMax;
    return PosW'(e - SizeW'(1));
  endfunction

endpackage

// ===== design/trapint4d_if.sv =====
// Stream channels of the integrator: sample input and integral output.
// Depends on trapint4d_pkg for field widths.
interface trapint4d_in_if;
  import trapint4d_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface trapint4d_out_if;
  import trapint4d_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [ResW-1:0] integral;
  logic                   saturated;
  modport source (output valid, output integral, output saturated, input ready);
  modport sink   (input valid, input integral, input saturated, output ready);
endinterface

// ===== design/trapezoid_integrator_4d.sv =====
// 4-D composite trapezoidal integrator: sample stream in, scaled integral out.
// Usage:
//   in_ch carries one Q16.16 sample per beat, in row-major order over a grid of
//   size_dim0 x size_dim1 x size_dim2 x size_dim3 points (dim3 innermost).
//   out_ch carries one beat per finished grid: integral (Q48.16, saturated to
//   signed 64 bits) and the saturated flag.
//   The APB port holds the four sizes (0x00..0x0C) and grid_step (0x10, Q8.24);
//   write it only while no grid is in flight.
// Throughput: one sample per cycle but for the stall below. The scaling unit
//   runs 13 partial products on a single 32x32 multiplier, each in a multiply
//   and an accumulate state, and takes a new grid only once the last result
//   is registered; a two-entry grid queue holds grids meanwhile, and in_ch
//   drops ready only on the closing beat of a grid while the queue is full.
// Path: queue, then S_MUL/S_ACC per partial product, S_ROUND, S_DONE.
// Reset (rst_n low, synchronous) clears the sums, positions, queue and output,
//   and loads sizes of 2 and a grid_step of 1.0. A stalled out_ch holds its
//   beat; the scaling unit waits, then the queue fills, then in_ch stalls.
module trapezoid_integrator_4d
  import trapint4d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  trapint4d_in_if.sink      in_ch,
  trapint4d_out_if.source   out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  sizes_t            sizes_r;
  logic [StepW-1:0]  step_r;
  logic              wr_en;
  reg_idx_t          reg_idx;
  logic              fq_valid, fq_ready;
  job_t              fq_data;
  logic              qb_valid, qb_ready;
  job_t              qb_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sizes_r <= {NumDims{SizeReset}};
      step_r  <= StepReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SIZE_DIM0: sizes_r[0] <= pwdata[SizeW-1:0];
        REG_SIZE_DIM1: sizes_r[1] <= pwdata[SizeW-1:0];
        REG_SIZE_DIM2: sizes_r[2] <= pwdata[SizeW-1:0];
        REG_SIZE_DIM3: sizes_r[3] <= pwdata[SizeW-1:0];
        REG_GRID_STEP: step_r     <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIZE_DIM0: prdata = DataW'(sizes_r[0]);
      REG_SIZE_DIM1: prdata = DataW'(sizes_r[1]);
      REG_SIZE_DIM2: prdata = DataW'(sizes_r[2]);
      REG_SIZE_DIM3: prdata = DataW'(sizes_r[3]);
      REG_GRID_STEP: prdata = DataW'(step_r);
      default:       prdata = '0;
    endcase
  end

  trapint4d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .sizes     (sizes_r),
    .grid_step (step_r),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_data)
  );

  trapint4d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  trapint4d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== design/trapint4d_front.sv =====
// Front end: grid position counters, trapezoid weighting and running sum.
// Depends on trapint4d_pkg and trapint4d_in_if; hands finished grids to the queue.
module trapint4d_front
  import trapint4d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  trapint4d_in_if.sink         in_ch,
  input  sizes_t               sizes,
  input  logic [StepW-1:0]     grid_step,
  output logic                 job_valid,
  input  logic                 job_ready,
  output job_t                 job
);

  logic [NumDims-1:0][PosW-1:0] pos_r, pos_nxt;
  logic [SumW-1:0]              sum_r, sum_nxt;
  logic [NumDims-1:0][PosW-1:0] lim;
  logic [NumDims-1:0]           at_last;
  logic [NumDims-1:0]           on_bnd;
  logic [2:0]                   nb;
  logic                         grid_last;
  logic                         carry;
  logic [SumW-1:0]              s_ext;
  logic [SumW-1:0]              weighted;
  logic [SumW-1:0]              sum_add;
  logic                         accept;

  always_comb begin
    for (int d = 0; d < NumDims; d++) begin
      lim[d]     = last_idx(sizes[d]);
      at_last[d] = pos_r[d] >= lim[d];
      on_bnd[d]  = (pos_r[d] == '0) || at_last[d];
    end
    nb        = 3'($countones(on_bnd));
    grid_last = &at_last;

    // Innermost dimension is index 3; ripple the carry outward.
    carry = 1'b1;
    for (int d = NumDims - 1; d >= 0; d--) begin
      pos_nxt[d] = pos_r[d];
      if (carry) begin
        pos_nxt[d] = at_last[d] ? '0 : pos_r[d] + PosW'(1);
        carry      = at_last[d];
      end
    end

    s_ext    = {{(SumW-SampleW){in_ch.sample[SampleW-1]}}, in_ch.sample};
    weighted = s_ext << (3'd4 - nb);
    sum_add  = sum_r + weighted;
  end

  // Only the closing beat of a grid needs room in the queue.
  assign in_ch.ready = !grid_last || job_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign job_valid   = accept && grid_last;
  assign job.sum     = sum_add;
  assign job.step    = grid_step;

  always_comb begin
    sum_nxt = sum_r;
    if (accept) begin
      sum_nxt = grid_last ? '0 : sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      if (accept) begin
        pos_r <= grid_last ? '0 : pos_nxt;
      end
    end
  end

endmodule

// ===== design/trapint4d_queue.sv =====
// Two-entry queue of finished grids between the front and back ends.
// Depends on trapint4d_pkg for job_t and depth constants.
module trapint4d_queue
  import trapint4d_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QCntW-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = cnt_r != QCntW'(QDepth);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + QCntW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - QCntW'(1);
    end
  end

endmodule

// ===== design/trapint4d_back.sv =====
// Back end: scales a grid sum by grid_step^4 on one shared 32x32 multiplier,
// rounds, saturates and holds the result. Depends on trapint4d_pkg, trapint4d_out_if.
module trapint4d_back
  import trapint4d_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  job_t           job,
  trapint4d_out_if.source out_ch
);

  localparam logic [3:0] StepSt2     = 4'd0;
  localparam logic [3:0] StepSt4Last = 4'd4;
  localparam logic [3:0] StepProd    = 4'd5;
  localparam logic [3:0] StepLast    = 4'd12;
  localparam logic [AccW-1:0] RoundInc = AccW'(1) << (FracCut - 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_ROUND, S_DONE} state_t;

  state_t              state_r;
  logic [SumW-1:0]     mag_r;
  logic                neg_r;
  logic [StepW-1:0]    step_r;
  logic [2*LimbW-1:0]  st2_r;
  logic [4*LimbW-1:0]  st4_r;
  logic [AccW-1:0]     acc_r;
  logic [ProdW-1:0]    prod_r;
  logic [3:0]          idx_r;
  logic                out_valid_r;
  logic [ResW-1:0]     integral_r;
  logic                saturated_r;

  logic [LimbW-1:0]    op_a, op_b;
  logic [2:0]          sh;
  logic [1:0]          k4;
  logic [2:0]          kp;
  logic [AccW-1:0]     acc_nxt;
  logic                over;
  logic [ResW-1:0]     res, lim, val;
  logic                sat;
  logic                out_free;

  // Pick the limb pair and its column for the current partial product.
  always_comb begin
    k4   = 2'(idx_r - 4'd1);
    kp   = 3'(idx_r - StepProd);
    op_a = step_r;
    op_b = step_r;
    sh   = '0;
    if (idx_r == StepSt2) begin
      op_a = step_r;
      op_b = step_r;
      sh   = '0;
    end else if (idx_r <= StepSt4Last) begin
      op_a = st2_r[LimbW*k4[1] +: LimbW];
      op_b = st2_r[LimbW*k4[0] +: LimbW];
      sh   = 3'(k4[1]) + 3'(k4[0]);
    end else begin
      op_a = kp[2] ? LimbW'(mag_r[SumW-1:LimbW]) : mag_r[LimbW-1:0];
      op_b = st4_r[LimbW*kp[1:0] +: LimbW];
      sh   = 3'(kp[2]) + 3'(kp[1:0]);
    end
    acc_nxt = acc_r + (AccW'(prod_r) << {sh, 5'd0});
  end

  always_comb begin
    over = |acc_r[AccW-1:FracCut+ResW];
    res  = acc_r[FracCut+ResW-1:FracCut];
    lim  = neg_r ? ResNegMax : ResPosMax;
    sat  = over || (res > lim);
    val  = sat ? lim : res;
  end

  assign out_free  = !out_valid_r || out_ch.ready;
  assign job_ready = state_r == S_IDLE;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.integral  = integral_r;
  assign out_ch.saturated = saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      // S_DONE sets or holds the beat on its own
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            neg_r   <= job.sum[SumW-1];
            mag_r   <= job.sum[SumW-1] ? SumW'(0) - job.sum : job.sum;
            step_r  <= job.step;
            acc_r   <= '0;
            idx_r   <= StepSt2;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= op_a * op_b;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (idx_r == StepSt2) begin
            st2_r <= acc_nxt[2*LimbW-1:0];
            acc_r <= '0;
          end else if (idx_r == StepSt4Last) begin
            st4_r <= acc_nxt[4*LimbW-1:0];
            acc_r <= '0;
          end else begin
            acc_r <= acc_nxt;
          end
          if (idx_r == StepLast) begin
            state_r <= S_ROUND;
          end else begin
            idx_r   <= idx_r + 4'd1;
            state_r <= S_MUL;
          end
        end
        S_ROUND: begin
          // half away from zero on the magnitude
          acc_r   <= acc_r + RoundInc;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            integral_r  <= neg_r ? ResW'(0) - val : val;
            saturated_r <= sat;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/trapint4d_chk.sv =====
// Port-level checks for the integrator, bound to the top level.
// Depends on trapint4d_pkg and on the top level trapezoid_integrator_4d.
module trapint4d_chk
  import trapint4d_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ResW-1:0] integral,
  input logic            saturated
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(integral) && $stable(saturated))
    else $error("result beat changed while stalled");

  // A clipped result sits exactly at one of the range limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> integral == ResPosMax || integral == ResNegMax)
    else $error("saturated result not at a limit");

  // Drop the output beat on reset.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh grid after reset can always take its first sample.
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind trapezoid_integrator_4d trapint4d_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .integral  (out_ch.integral),
  .saturated (out_ch.saturated)
);
